/* sv/ppsd_pkg.sv */
package ppsd_pkg;

  localparam int NROWS = 282;
  localparam int CLASS_W = 9;

  // Which low bits of the extended index a row compares
  typedef enum logic [1:0] {
    CARE_NONE = 2'd0,
    CARE_X    = 2'd1,
    CARE_S    = 2'd2,
    CARE_H    = 2'd3
  } care_t;

  typedef struct packed {
    logic [5:0]  prim;
    logic [10:0] key;
    care_t       care;
  } row_t;

  localparam logic [10:0] MASK_X = 11'h7ff;
  localparam logic [10:0] MASK_S = 11'h03f;
  localparam logic [10:0] MASK_H = 11'h07f;

  localparam logic [CLASS_W-1:0] CLASS_UNIMPL = 9'd0;
  localparam logic [CLASS_W-1:0] CLASS_HLE    = 9'd1;
  localparam logic [CLASS_W-1:0] CLASS_BASE   = 9'd2;

  function automatic logic [10:0] care_mask(care_t c);
    logic [10:0] m;
    unique case (c)
      CARE_NONE: m = 11'h000;
      CARE_X:    m = MASK_X;
      CARE_S:    m = MASK_S;
      CARE_H:    m = MASK_H;
      default:   m = 11'h000;
    endcase
    return m;
  endfunction

  // Class table, in class id order
  localparam row_t ROWS [NROWS] = '{
    // primary-only classes
    '{6'd3,11'd0,CARE_NONE}, '{6'd7,11'd0,CARE_NONE}, '{6'd8,11'd0,CARE_NONE},
    '{6'd10,11'd0,CARE_NONE}, '{6'd11,11'd0,CARE_NONE}, '{6'd12,11'd0,CARE_NONE},
    '{6'd13,11'd0,CARE_NONE}, '{6'd14,11'd0,CARE_NONE}, '{6'd15,11'd0,CARE_NONE},
    '{6'd16,11'd0,CARE_NONE}, '{6'd17,11'd0,CARE_NONE}, '{6'd18,11'd0,CARE_NONE},
    '{6'd20,11'd0,CARE_NONE}, '{6'd21,11'd0,CARE_NONE}, '{6'd23,11'd0,CARE_NONE},
    '{6'd24,11'd0,CARE_NONE}, '{6'd25,11'd0,CARE_NONE}, '{6'd26,11'd0,CARE_NONE},
    '{6'd27,11'd0,CARE_NONE}, '{6'd28,11'd0,CARE_NONE}, '{6'd29,11'd0,CARE_NONE},
    '{6'd32,11'd0,CARE_NONE}, '{6'd33,11'd0,CARE_NONE}, '{6'd34,11'd0,CARE_NONE},
    '{6'd35,11'd0,CARE_NONE}, '{6'd36,11'd0,CARE_NONE}, '{6'd37,11'd0,CARE_NONE},
    '{6'd38,11'd0,CARE_NONE}, '{6'd39,11'd0,CARE_NONE},
    '{6'd40,11'd0,CARE_NONE}, '{6'd41,11'd0,CARE_NONE}, '{6'd42,11'd0,CARE_NONE},
    '{6'd43,11'd0,CARE_NONE}, '{6'd44,11'd0,CARE_NONE}, '{6'd45,11'd0,CARE_NONE},
    '{6'd46,11'd0,CARE_NONE}, '{6'd47,11'd0,CARE_NONE},
    '{6'd48,11'd0,CARE_NONE}, '{6'd49,11'd0,CARE_NONE}, '{6'd50,11'd0,CARE_NONE},
    '{6'd51,11'd0,CARE_NONE}, '{6'd52,11'd0,CARE_NONE}, '{6'd53,11'd0,CARE_NONE},
    '{6'd54,11'd0,CARE_NONE}, '{6'd55,11'd0,CARE_NONE},
    '{6'd56,11'd0,CARE_NONE}, '{6'd57,11'd0,CARE_NONE}, '{6'd60,11'd0,CARE_NONE},
    '{6'd61,11'd0,CARE_NONE},
    // primary 19
    '{6'd19,11'd0,CARE_X}, '{6'd19,11'd32,CARE_X}, '{6'd19,11'd33,CARE_X},
    '{6'd19,11'd66,CARE_X}, '{6'd19,11'd100,CARE_X}, '{6'd19,11'd258,CARE_X},
    '{6'd19,11'd300,CARE_X}, '{6'd19,11'd386,CARE_X}, '{6'd19,11'd450,CARE_X},
    '{6'd19,11'd514,CARE_X}, '{6'd19,11'd578,CARE_X}, '{6'd19,11'd834,CARE_X},
    '{6'd19,11'd898,CARE_X}, '{6'd19,11'd1056,CARE_X}, '{6'd19,11'd1057,CARE_X},
    // primary 31
    '{6'd31,11'd0,CARE_X}, '{6'd31,11'd8,CARE_X}, '{6'd31,11'd16,CARE_X},
    '{6'd31,11'd17,CARE_X}, '{6'd31,11'd20,CARE_X}, '{6'd31,11'd21,CARE_X},
    '{6'd31,11'd22,CARE_X}, '{6'd31,11'd23,CARE_X}, '{6'd31,11'd38,CARE_X},
    '{6'd31,11'd40,CARE_X}, '{6'd31,11'd46,CARE_X}, '{6'd31,11'd48,CARE_X},
    '{6'd31,11'd49,CARE_X}, '{6'd31,11'd52,CARE_X}, '{6'd31,11'd53,CARE_X},
    '{6'd31,11'd56,CARE_X}, '{6'd31,11'd57,CARE_X}, '{6'd31,11'd64,CARE_X},
    '{6'd31,11'd80,CARE_X}, '{6'd31,11'd81,CARE_X}, '{6'd31,11'd108,CARE_X},
    '{6'd31,11'd110,CARE_X}, '{6'd31,11'd120,CARE_X}, '{6'd31,11'd121,CARE_X},
    '{6'd31,11'd150,CARE_X}, '{6'd31,11'd151,CARE_X}, '{6'd31,11'd166,CARE_X},
    '{6'd31,11'd172,CARE_X}, '{6'd31,11'd174,CARE_X}, '{6'd31,11'd208,CARE_X},
    '{6'd31,11'd209,CARE_X}, '{6'd31,11'd238,CARE_X}, '{6'd31,11'd248,CARE_X},
    '{6'd31,11'd249,CARE_X}, '{6'd31,11'd272,CARE_X}, '{6'd31,11'd273,CARE_X},
    '{6'd31,11'd276,CARE_X}, '{6'd31,11'd277,CARE_X}, '{6'd31,11'd288,CARE_X},
    '{6'd31,11'd292,CARE_X}, '{6'd31,11'd301,CARE_X}, '{6'd31,11'd302,CARE_X},
    '{6'd31,11'd366,CARE_X}, '{6'd31,11'd400,CARE_X}, '{6'd31,11'd401,CARE_X},
    '{6'd31,11'd404,CARE_X}, '{6'd31,11'd405,CARE_X}, '{6'd31,11'd420,CARE_X},
    '{6'd31,11'd430,CARE_X}, '{6'd31,11'd464,CARE_X}, '{6'd31,11'd465,CARE_X},
    '{6'd31,11'd468,CARE_X}, '{6'd31,11'd469,CARE_X}, '{6'd31,11'd470,CARE_X},
    '{6'd31,11'd471,CARE_X}, '{6'd31,11'd484,CARE_X}, '{6'd31,11'd492,CARE_X},
    '{6'd31,11'd494,CARE_X}, '{6'd31,11'd532,CARE_X}, '{6'd31,11'd533,CARE_X},
    '{6'd31,11'd556,CARE_X}, '{6'd31,11'd558,CARE_X}, '{6'd31,11'd568,CARE_X},
    '{6'd31,11'd569,CARE_X}, '{6'd31,11'd612,CARE_X}, '{6'd31,11'd622,CARE_X},
    '{6'd31,11'd632,CARE_X}, '{6'd31,11'd633,CARE_X}, '{6'd31,11'd678,CARE_X},
    '{6'd31,11'd686,CARE_X}, '{6'd31,11'd742,CARE_X}, '{6'd31,11'd750,CARE_X},
    '{6'd31,11'd814,CARE_X}, '{6'd31,11'd824,CARE_X}, '{6'd31,11'd825,CARE_X},
    '{6'd31,11'd878,CARE_X}, '{6'd31,11'd888,CARE_X}, '{6'd31,11'd889,CARE_X},
    '{6'd31,11'd918,CARE_X}, '{6'd31,11'd919,CARE_X}, '{6'd31,11'd934,CARE_X},
    '{6'd31,11'd940,CARE_X}, '{6'd31,11'd952,CARE_X}, '{6'd31,11'd953,CARE_X},
    '{6'd31,11'd982,CARE_X}, '{6'd31,11'd983,CARE_X}, '{6'd31,11'd1024,CARE_X},
    '{6'd31,11'd1044,CARE_X}, '{6'd31,11'd1045,CARE_X}, '{6'd31,11'd1068,CARE_X},
    '{6'd31,11'd1070,CARE_X}, '{6'd31,11'd1072,CARE_X}, '{6'd31,11'd1073,CARE_X},
    '{6'd31,11'd1132,CARE_X}, '{6'd31,11'd1134,CARE_X}, '{6'd31,11'd1190,CARE_X},
    '{6'd31,11'd1194,CARE_X}, '{6'd31,11'd1196,CARE_X}, '{6'd31,11'd1198,CARE_X},
    '{6'd31,11'd1262,CARE_X}, '{6'd31,11'd1318,CARE_X}, '{6'd31,11'd1324,CARE_X},
    '{6'd31,11'd1326,CARE_X}, '{6'd31,11'd1390,CARE_X}, '{6'd31,11'd1450,CARE_X},
    '{6'd31,11'd1454,CARE_X}, '{6'd31,11'd1518,CARE_X}, '{6'd31,11'd1556,CARE_X},
    '{6'd31,11'd1557,CARE_X}, '{6'd31,11'd1580,CARE_X}, '{6'd31,11'd1584,CARE_X},
    '{6'd31,11'd1585,CARE_X}, '{6'd31,11'd1648,CARE_X}, '{6'd31,11'd1649,CARE_X},
    '{6'd31,11'd1708,CARE_X}, '{6'd31,11'd1836,CARE_X}, '{6'd31,11'd1844,CARE_X},
    '{6'd31,11'd1845,CARE_X}, '{6'd31,11'd1908,CARE_X}, '{6'd31,11'd1909,CARE_X},
    '{6'd31,11'd1964,CARE_X}, '{6'd31,11'd1966,CARE_X}, '{6'd31,11'd2028,CARE_X},
    // primary 59
    '{6'd59,11'd36,CARE_S}, '{6'd59,11'd37,CARE_S}, '{6'd59,11'd40,CARE_S},
    '{6'd59,11'd41,CARE_S}, '{6'd59,11'd42,CARE_S}, '{6'd59,11'd43,CARE_S},
    '{6'd59,11'd48,CARE_S}, '{6'd59,11'd49,CARE_S}, '{6'd59,11'd50,CARE_S},
    '{6'd59,11'd51,CARE_S}, '{6'd59,11'd56,CARE_S}, '{6'd59,11'd57,CARE_S},
    '{6'd59,11'd58,CARE_S}, '{6'd59,11'd59,CARE_S}, '{6'd59,11'd60,CARE_S},
    '{6'd59,11'd61,CARE_S}, '{6'd59,11'd62,CARE_S}, '{6'd59,11'd63,CARE_S},
    // primary 63
    '{6'd63,11'd0,CARE_X}, '{6'd63,11'd24,CARE_X}, '{6'd63,11'd25,CARE_X},
    '{6'd63,11'd28,CARE_X}, '{6'd63,11'd29,CARE_X}, '{6'd63,11'd30,CARE_X},
    '{6'd63,11'd31,CARE_X}, '{6'd63,11'd36,CARE_X}, '{6'd63,11'd37,CARE_X},
    '{6'd63,11'd40,CARE_X}, '{6'd63,11'd41,CARE_X}, '{6'd63,11'd42,CARE_X},
    '{6'd63,11'd43,CARE_X}, '{6'd63,11'd46,CARE_S}, '{6'd63,11'd47,CARE_S},
    '{6'd63,11'd50,CARE_S}, '{6'd63,11'd51,CARE_S}, '{6'd63,11'd52,CARE_X},
    '{6'd63,11'd53,CARE_X}, '{6'd63,11'd56,CARE_S}, '{6'd63,11'd57,CARE_S},
    '{6'd63,11'd58,CARE_S}, '{6'd63,11'd59,CARE_S}, '{6'd63,11'd60,CARE_S},
    '{6'd63,11'd61,CARE_S}, '{6'd63,11'd62,CARE_S}, '{6'd63,11'd63,CARE_S},
    '{6'd63,11'd64,CARE_X}, '{6'd63,11'd76,CARE_X}, '{6'd63,11'd77,CARE_X},
    '{6'd63,11'd80,CARE_X}, '{6'd63,11'd81,CARE_X}, '{6'd63,11'd128,CARE_X},
    '{6'd63,11'd140,CARE_X}, '{6'd63,11'd141,CARE_X}, '{6'd63,11'd144,CARE_X},
    '{6'd63,11'd145,CARE_X}, '{6'd63,11'd272,CARE_X}, '{6'd63,11'd273,CARE_X},
    '{6'd63,11'd528,CARE_X}, '{6'd63,11'd529,CARE_X}, '{6'd63,11'd1166,CARE_X},
    '{6'd63,11'd1167,CARE_X}, '{6'd63,11'd1422,CARE_X}, '{6'd63,11'd1423,CARE_X},
    // primary 4 (paired single)
    '{6'd4,11'd0,CARE_X}, '{6'd4,11'd12,CARE_H}, '{6'd4,11'd14,CARE_H},
    '{6'd4,11'd20,CARE_S}, '{6'd4,11'd22,CARE_S}, '{6'd4,11'd24,CARE_S},
    '{6'd4,11'd26,CARE_S}, '{6'd4,11'd28,CARE_S}, '{6'd4,11'd30,CARE_S},
    '{6'd4,11'd36,CARE_X}, '{6'd4,11'd40,CARE_X}, '{6'd4,11'd42,CARE_X},
    '{6'd4,11'd46,CARE_S}, '{6'd4,11'd48,CARE_X}, '{6'd4,11'd50,CARE_S},
    '{6'd4,11'd52,CARE_X}, '{6'd4,11'd56,CARE_S}, '{6'd4,11'd58,CARE_S},
    '{6'd4,11'd60,CARE_S}, '{6'd4,11'd62,CARE_S}, '{6'd4,11'd64,CARE_X},
    '{6'd4,11'd76,CARE_H}, '{6'd4,11'd78,CARE_H}, '{6'd4,11'd80,CARE_X},
    '{6'd4,11'd144,CARE_X}, '{6'd4,11'd128,CARE_X}, '{6'd4,11'd192,CARE_X},
    '{6'd4,11'd1056,CARE_X}, '{6'd4,11'd1120,CARE_X}, '{6'd4,11'd1184,CARE_X},
    '{6'd4,11'd1248,CARE_X}, '{6'd4,11'd2028,CARE_X}
  };

endpackage

/* sv/ppsd_in_if.sv */
interface ppsd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

/* sv/ppsd_out_if.sv */
interface ppsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppsd_pkg::CLASS_W-1:0]  class_id;
  logic                          not_implemented;
  logic                          null_call;
  logic [31:0]                   rotate_mask;

  modport source (output valid, output class_id, output not_implemented,
                  output null_call, output rotate_mask, input ready);
  modport sink   (input valid, input class_id, input not_implemented,
                  input null_call, input rotate_mask, output ready);
endinterface

/* sv/ppc_paired_single_instr_decoder_unit.sv */
// Instruction class decoder: one 32-bit word per transfer in, one class result
// per transfer out, one item per cycle while the output is not stalled. Registers
// in order: input register, table match register, encode/output register; the whole
// pipeline holds while the output transfer is stalled, so nothing is dropped.
module ppc_paired_single_instr_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  ppsd_in_if.sink    in_ch,
  ppsd_out_if.source out_ch
);

  localparam int N = ppsd_pkg::NROWS;
  localparam int IW = $clog2(N);

  logic adv;

  // stage 1: captured word
  logic        v1_r;
  logic [31:0] w1_r;

  // stage 2: row hits and partial mask
  logic             v2_r;
  logic [N-1:0]     hit_r, hit_nxt;
  logic             prim0_r, zero_r, inv_r;
  logic [31:0]      mask_r, mask_nxt;

  // stage 3: output register
  logic                          v3_r;
  logic [ppsd_pkg::CLASS_W-1:0]  cls_r, cls_nxt;
  logic                          nimp_r, nimp_nxt;
  logic                          null_r;
  logic [31:0]                   rot_r;

  assign adv = !v3_r || out_ch.ready;
  assign in_ch.ready = adv;

  // row match, one compare per table row
  always_comb begin
    logic [4:0] mb, me;
    logic [31:0] lo;
    for (int i = 0; i < N; i++) begin
      hit_nxt[i] = (w1_r[31:26] == ppsd_pkg::ROWS[i].prim) &&
                   ((w1_r[10:0] & ppsd_pkg::care_mask(ppsd_pkg::ROWS[i].care))
                    == ppsd_pkg::ROWS[i].key);
    end
    mb = w1_r[10:6];
    me = w1_r[5:1];
    lo = (me == 5'd31) ? 32'h0 : (32'hffffffff >> ({1'b0, me} + 6'd1));
    mask_nxt = (32'hffffffff >> mb) ^ lo;
  end

  // first hit wins
  always_comb begin
    logic [IW-1:0] idx;
    logic found;
    idx = '0;
    found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        idx = IW'(i);
        found = 1'b1;
      end
    end
    if (prim0_r) begin
      cls_nxt = ppsd_pkg::CLASS_HLE;
    end else if (found) begin
      cls_nxt = ppsd_pkg::CLASS_BASE + ppsd_pkg::CLASS_W'(idx);
    end else begin
      cls_nxt = ppsd_pkg::CLASS_UNIMPL;
    end
    nimp_nxt = !prim0_r && !found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r    <= in_ch.instr_word;
      hit_r   <= hit_nxt;
      prim0_r <= (w1_r[31:26] == 6'd0);
      zero_r  <= (w1_r == 32'd0);
      inv_r   <= (w1_r[10:6] > w1_r[5:1]);
      mask_r  <= mask_nxt;
      cls_r   <= cls_nxt;
      nimp_r  <= nimp_nxt;
      null_r  <= zero_r;
      rot_r   <= inv_r ? ~mask_r : mask_r;
    end
  end

  assign out_ch.valid           = v3_r;
  assign out_ch.class_id        = cls_r;
  assign out_ch.not_implemented = nimp_r;
  assign out_ch.null_call       = null_r;
  assign out_ch.rotate_mask     = rot_r;

endmodule

/* bench/ppc_paired_single_instr_decoder_unit_tb.sv */
module ppc_paired_single_instr_decoder_unit_tb;

  // One decoded instruction
  typedef struct {
    logic [ppsd_pkg::CLASS_W-1:0] class_id;
    logic                         not_implemented;
    logic                         null_call;
    logic [31:0]                  rotate_mask;
  } decode_t;

  // Directed row: word, and whether a hand-written result applies
  typedef struct {
    logic [31:0] word;
    bit          typed;
    decode_t     res;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned n_err = 0;
  bit sending_done = 1'b0;
  bit tail_phase = 1'b0;
  bit long_hold = 1'b0;
  decode_t pending_decodes[$];

  ppsd_in_if  in_ch();
  ppsd_out_if out_ch();

  ppc_paired_single_instr_decoder_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // Rotate mask from the MB and ME fields
  function automatic logic [31:0] mb_me_mask(logic [4:0] mb, logic [4:0] me);
    logic [31:0] m;
    m = (32'hffff_ffff >> mb) ^ ((me == 5'd31) ? 32'h0 : (32'hffff_ffff >> (me + 6'd1)));
    return (mb > me) ? ~m : m;
  endfunction

  // Class table lookup, first match wins
  function automatic decode_t decode_word(logic [31:0] w);
    decode_t r;
    logic [5:0] prim;
    logic [10:0] ext;
    logic [10:0] sel;
    int cls;
    prim = w[31:26];
    ext = w[10:0];
    cls = 0;
    if (prim == 6'd0) cls = 1;
    else begin
      for (int i = 0; i < ppsd_pkg::NROWS; i++) begin
        case (ppsd_pkg::ROWS[i].care)
          ppsd_pkg::CARE_X: sel = 11'h7ff;
          ppsd_pkg::CARE_S: sel = 11'h03f;
          ppsd_pkg::CARE_H: sel = 11'h07f;
          default:          sel = 11'h000;
        endcase
        if (cls == 0 && ppsd_pkg::ROWS[i].prim == prim && (ext & sel) == ppsd_pkg::ROWS[i].key)
          cls = i + 2;
      end
    end
    r.class_id = cls[ppsd_pkg::CLASS_W-1:0];
    r.not_implemented = (cls == 0);
    r.null_call = (w == 32'h0);
    r.rotate_mask = mb_me_mask(w[10:6], w[5:1]);
    return r;
  endfunction

  // Random word, mostly from implemented spaces
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    int k;
    w = $urandom();
    k = $urandom_range(0, 9);
    if (k < 7) begin
      int r;
      r = $urandom_range(0, ppsd_pkg::NROWS - 1);
      w[31:26] = ppsd_pkg::ROWS[r].prim;
      case (ppsd_pkg::ROWS[r].care)
        ppsd_pkg::CARE_X: w[10:0] = ppsd_pkg::ROWS[r].key;
        ppsd_pkg::CARE_S: w[5:0] = ppsd_pkg::ROWS[r].key[5:0];
        ppsd_pkg::CARE_H: w[6:0] = ppsd_pkg::ROWS[r].key[6:0];
        default: ;
      endcase
    end else if (k == 7) begin
      w[31:26] = 6'd0;
    end
    return w;
  endfunction

  // Hand-checked rows plus predictor-checked rows
  function automatic vec_t row(logic [31:0] w, bit typed, int cls, bit ni, bit nc, logic [31:0] m);
    vec_t v;
    v.word = w;
    v.typed = typed;
    v.res.class_id = cls[ppsd_pkg::CLASS_W-1:0];
    v.res.not_implemented = ni;
    v.res.null_call = nc;
    v.res.rotate_mask = m;
    return v;
  endfunction

  vec_t directed[$];

  initial begin
    directed.push_back(row(32'h0000_0000, 1, 1, 0, 1, 32'h8000_0000));
    directed.push_back(row(32'h0000_0001, 1, 1, 0, 0, 32'h8000_0000));
    directed.push_back(row(32'h0400_0000, 1, 0, 1, 0, 32'h8000_0000));
    directed.push_back(row(32'h0c00_0000, 1, 2, 0, 0, 32'h8000_0000));
    directed.push_back(row(32'hffff_ffff, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h0000_07c0, 1, 1, 0, 0, 32'h0000_0001 | 32'h8000_0000));
    directed.push_back(row(32'h0000_003e, 1, 1, 0, 0, 32'hffff_ffff));
    directed.push_back(row(32'h0000_0040, 1, 1, 0, 0, 32'hffff_ffff));
    directed.push_back(row(32'h7c00_0000, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h7c00_07ff, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h4c00_0421, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h4c00_0001, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hec00_07e4, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hec00_0000, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hfc00_058f, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hfc00_07ee, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h1000_078c, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h1000_07ec, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h1000_07ee, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h1000_0002, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hf800_0000, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h0800_0000, 0, 0, 0, 0, 0));
  end

  // Sender
  initial begin
    int n_sent;
    logic [31:0] w;
    decode_t e;
    in_ch.valid <= 1'b0;
    in_ch.instr_word <= 32'h0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    n_sent = 0;
    while (n_sent < directed.size() + 550) begin
      if (n_sent < directed.size()) begin
        w = directed[n_sent].word;
        e = directed[n_sent].typed ? directed[n_sent].res : decode_word(w);
      end else begin
        w = pick_word();
        e = decode_word(w);
      end
      tail_phase = (n_sent > directed.size() + 450);
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.instr_word <= w;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      pending_decodes.push_back(e);
      n_sent++;
      if (n_sent == directed.size() + 100) long_hold = 1'b1;
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver ready, with one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result check
  always @(posedge clk) begin
    decode_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_decodes.size() == 0) begin
        $error("unexpected transfer, class_id %0d", out_ch.class_id);
        n_err++;
      end else begin
        e = pending_decodes.pop_front();
        if (out_ch.class_id !== e.class_id) begin
          $error("class_id expected %0d actual %0d", e.class_id, out_ch.class_id);
          n_err++;
        end
        if (out_ch.not_implemented !== e.not_implemented) begin
          $error("not_implemented expected %0b actual %0b", e.not_implemented,
                 out_ch.not_implemented);
          n_err++;
        end
        if (out_ch.null_call !== e.null_call) begin
          $error("null_call expected %0b actual %0b", e.null_call, out_ch.null_call);
          n_err++;
        end
        if (out_ch.rotate_mask !== e.rotate_mask) begin
          $error("rotate_mask expected %h actual %h", e.rotate_mask, out_ch.rotate_mask);
          n_err++;
        end
      end
    end
  end

  // End of run and timeout
  initial begin
    wait (sending_done);
    while (pending_decodes.size() != 0 && cycle_cnt < 200000) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_err == 0 && pending_decodes.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 200000) begin
      $display("tb: failure");
      $finish;
    end
  end
endmodule

/* files.f */
sv/ppsd_pkg.sv
sv/ppsd_in_if.sv
sv/ppsd_out_if.sv
sv/ppc_paired_single_instr_decoder_unit.sv
bench/ppc_paired_single_instr_decoder_unit_tb.sv
